// File: design/tpe_pkg.sv
package tpe_pkg;

  // Register indexes on the configuration port
  typedef enum logic [2:0] {
    REG_MODE        = 3'd0,
    REG_PILOT_LEN   = 3'd1,
    REG_PILOT_CNT   = 3'd2,
    REG_SYNC1_LEN   = 3'd3,
    REG_SYNC2_LEN   = 3'd4,
    REG_ZERO_LEN    = 3'd5,
    REG_ONE_LEN     = 3'd6,
    REG_LAST_BITS   = 3'd7
  } reg_idx_e;

  // Mode codes
  localparam logic [1:0] MODE_STD   = 2'd0;
  localparam logic [1:0] MODE_TURBO = 2'd1;

  // Standard-speed timing, in clock cycles
  localparam logic [15:0] STD_PILOT_LEN    = 16'd2168;
  localparam logic [15:0] STD_PILOT_HEADER = 16'd8063;
  localparam logic [15:0] STD_PILOT_DATA   = 16'd3223;
  localparam logic [15:0] STD_SYNC1        = 16'd667;
  localparam logic [15:0] STD_SYNC2        = 16'd735;
  localparam logic [15:0] STD_ZERO         = 16'd855;
  localparam logic [15:0] STD_ONE          = 16'd1710;
  localparam logic [3:0]  STD_BITS         = 4'd8;
  localparam logic [7:0]  HEADER_LIMIT     = 8'd128;

  // Pause: two pulses of half a millisecond each at 3.5 MHz
  localparam int unsigned CLOCK_HZ       = 3500000;
  localparam int unsigned PAUSE_HALF_MS  = CLOCK_HZ / 1000 / 2;
  localparam logic [10:0] PAUSE_MULT     = 11'(PAUSE_HALF_MS);

  localparam int unsigned LEN_W = 27;
  localparam int unsigned CNT_W = 16;

  // Descriptor queue depth between front and back
  localparam int unsigned JOB_QUEUE_DEPTH = 2;

  // Configuration register file
  typedef struct packed {
    logic [1:0]  mode;
    logic [15:0] pilot_length;
    logic [15:0] pilot_count;
    logic [15:0] first_sync_length;
    logic [15:0] second_sync_length;
    logic [15:0] zero_length;
    logic [15:0] one_length;
    logic [3:0]  last_byte_bits;
  } cfg_t;

  // One classified byte, ready for the sequencer
  typedef struct packed {
    logic [7:0]  data;
    logic        std_mode;
    logic        pilot_en;
    logic [15:0] pilot_cnt;
    logic        sync_en;
    logic [3:0]  nbits;
    logic        pause_en;
    logic [15:0] pause;
  } job_t;

endpackage

// File: design/tpe_front.sv
module tpe_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  tpe_pkg::cfg_t   cfg_i,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  logic [7:0]      data_byte_i,
  input  logic            first_of_block_i,
  input  logic            last_of_block_i,
  input  logic [15:0]     pause_ms_i,
  output logic            push_o,
  output tpe_pkg::job_t   job_o,
  input  logic            full_i
);

  logic       std_mode;
  logic       turbo_mode;
  logic [3:0] bits_sat;
  logic       has_work;

  // Mode decode; modes two and three behave as pure data
  assign std_mode   = (cfg_i.mode == tpe_pkg::MODE_STD);
  assign turbo_mode = (cfg_i.mode == tpe_pkg::MODE_TURBO);
  assign bits_sat   = (cfg_i.last_byte_bits > tpe_pkg::STD_BITS) ?
                      tpe_pkg::STD_BITS : cfg_i.last_byte_bits;

  // Classify the byte into the phases it will produce
  always_comb begin
    job_o.data      = data_byte_i;
    job_o.std_mode  = std_mode;
    job_o.sync_en   = first_of_block_i && (std_mode || turbo_mode);
    job_o.pilot_cnt = std_mode ?
                      ((data_byte_i < tpe_pkg::HEADER_LIMIT) ? tpe_pkg::STD_PILOT_HEADER
                                                             : tpe_pkg::STD_PILOT_DATA) :
                      cfg_i.pilot_count;
    job_o.pilot_en  = job_o.sync_en && (job_o.pilot_cnt != 16'd0);
    job_o.nbits     = (!last_of_block_i || std_mode) ? tpe_pkg::STD_BITS : bits_sat;
    job_o.pause_en  = last_of_block_i && (pause_ms_i != 16'd0);
    job_o.pause     = pause_ms_i;
  end

  // A byte that yields no descriptor is consumed without a queue entry
  assign has_work   = job_o.sync_en || (job_o.nbits != 4'd0) || job_o.pause_en;
  assign in_stall_o = full_i;
  assign push_o     = in_valid_i && !full_i && has_work;

  // Queue never sees a push it cannot hold
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o |-> !full_i) else $error("push while queue full");

  a_sync_with_pilot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o && job_o.pilot_en |-> job_o.sync_en) else $error("pilot without sync");

  a_bits_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o |-> job_o.nbits <= tpe_pkg::STD_BITS) else $error("bit count above eight");

endmodule

// File: design/tpe_fifo.sv
module tpe_fifo #(
  parameter int unsigned Depth = tpe_pkg::JOB_QUEUE_DEPTH
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  tpe_pkg::job_t push_data_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          valid_o,
  output tpe_pkg::job_t pop_data_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(Depth);

  tpe_pkg::job_t  mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;

  assign full_o     = (cnt_q == CntFull);
  assign valid_o    = (cnt_q != '0);
  assign pop_data_o = mem_q[rd_ptr_q];

  // Entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> valid_o) else $error("pop from empty queue");

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntFull) else $error("queue count overflow");

  a_cnt_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i && !pop_i |=> cnt_q == $past(cnt_q) + 1'b1) else $error("count missed a push");

endmodule

// File: design/tpe_back.sv
module tpe_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  tpe_pkg::cfg_t               cfg_i,
  input  logic                        job_valid_i,
  input  tpe_pkg::job_t               job_i,
  output logic                        pop_o,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [tpe_pkg::LEN_W-1:0]   pulse_length_o,
  output logic [tpe_pkg::CNT_W-1:0]   pulse_count_o,
  output logic                        end_of_run_o
);

  typedef enum logic [2:0] {
    PH_PILOT,
    PH_SYNC1,
    PH_SYNC2,
    PH_BITS,
    PH_PAUSE
  } phase_e;

  tpe_pkg::job_t job_q;
  phase_e        phase_q, phase_nxt, phase_start;
  logic [2:0]    bit_q;
  logic          busy_q;
  logic          out_valid_q;
  logic [tpe_pkg::LEN_W-1:0] len_q, len_cur;
  logic [tpe_pkg::CNT_W-1:0] cnt_q, cnt_cur;
  logic          eor_q;
  logic          fire, is_last, last_bit, cur_bit;
  logic [15:0]   zl, ol;

  // Bit lengths follow the mode
  assign zl = job_q.std_mode ? tpe_pkg::STD_ZERO : cfg_i.zero_length;
  assign ol = job_q.std_mode ? tpe_pkg::STD_ONE  : cfg_i.one_length;

  assign last_bit = ({1'b0, bit_q} == (job_q.nbits - 4'd1));
  assign cur_bit  = job_q.data[3'd7 - bit_q];

  // First phase of a newly loaded job
  always_comb begin
    priority if (job_i.pilot_en)          phase_start = PH_PILOT;
    else if (job_i.sync_en)               phase_start = PH_SYNC1;
    else if (job_i.nbits != 4'd0)         phase_start = PH_BITS;
    else                                  phase_start = PH_PAUSE;
  end

  // Descriptor for the current phase and where to go next
  always_comb begin
    len_cur   = '0;
    cnt_cur   = 16'd2;
    phase_nxt = phase_q;
    is_last   = 1'b0;
    unique case (phase_q)
      PH_PILOT: begin
        len_cur   = tpe_pkg::LEN_W'(job_q.std_mode ? tpe_pkg::STD_PILOT_LEN
                                                   : cfg_i.pilot_length);
        cnt_cur   = job_q.pilot_cnt;
        phase_nxt = PH_SYNC1;
      end
      PH_SYNC1: begin
        len_cur   = tpe_pkg::LEN_W'(job_q.std_mode ? tpe_pkg::STD_SYNC1
                                                   : cfg_i.first_sync_length);
        cnt_cur   = 16'd1;
        phase_nxt = PH_SYNC2;
      end
      PH_SYNC2: begin
        len_cur   = tpe_pkg::LEN_W'(job_q.std_mode ? tpe_pkg::STD_SYNC2
                                                   : cfg_i.second_sync_length);
        cnt_cur   = 16'd1;
        phase_nxt = (job_q.nbits != 4'd0) ? PH_BITS : PH_PAUSE;
        is_last   = (job_q.nbits == 4'd0) && !job_q.pause_en;
      end
      PH_BITS: begin
        len_cur   = tpe_pkg::LEN_W'(cur_bit ? ol : zl);
        phase_nxt = last_bit ? PH_PAUSE : PH_BITS;
        is_last   = last_bit && !job_q.pause_en;
      end
      PH_PAUSE: begin
        len_cur   = tpe_pkg::LEN_W'(job_q.pause) * tpe_pkg::LEN_W'(tpe_pkg::PAUSE_MULT);
        is_last   = 1'b1;
      end
      default: begin
        phase_nxt = PH_PAUSE;
      end
    endcase
  end

  // One descriptor per cycle while a job is loaded and the output register is free
  assign fire  = busy_q && (!out_valid_q || !out_stall_i);
  assign pop_o = job_valid_i && (!busy_q || (fire && is_last));

  // Sequencer state and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
      phase_q     <= PH_PILOT;
      bit_q       <= '0;
      job_q       <= '0;
      len_q       <= '0;
      cnt_q       <= '0;
      eor_q       <= 1'b0;
    end else begin
      if (fire) begin
        out_valid_q <= 1'b1;
        len_q       <= len_cur;
        cnt_q       <= cnt_cur;
        eor_q       <= is_last;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      // A new job takes over in the cycle the previous one finishes
      if (pop_o) begin
        job_q   <= job_i;
        busy_q  <= 1'b1;
        phase_q <= phase_start;
        bit_q   <= '0;
      end else if (fire) begin
        if (is_last) begin
          busy_q <= 1'b0;
        end
        if (phase_q == PH_BITS) begin
          bit_q <= bit_q + 3'd1;
        end
        phase_q <= phase_nxt;
      end
    end
  end

  assign out_valid_o    = out_valid_q;
  assign pulse_length_o = len_q;
  assign pulse_count_o  = cnt_q;
  assign end_of_run_o   = eor_q;

  a_bits_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q && phase_q == PH_BITS |-> job_q.nbits != 4'd0 && {1'b0, bit_q} < job_q.nbits)
    else $error("bit phase past bit count");

  a_pause_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q && phase_q == PH_PAUSE |-> job_q.pause_en) else $error("pause phase without pause");

  a_pilot_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q && phase_q == PH_PILOT |-> job_q.pilot_en) else $error("pilot phase without pilot");

endmodule

// File: design/tape_pulse_train_encoder_unit.sv
// Tape pulse train encoder. Each accepted byte becomes up to twelve pulse
// descriptors (length in cycles, repeat count, end_of_run on the byte's last
// one): pilot (if its count is nonzero) and two syncs on a block's first
// byte (not in pure-data mode), one descriptor per used bit MSB first, and
// a pause descriptor on the last byte when pause_ms is nonzero. A byte that
// yields no descriptor is taken and dropped without a queue entry. The
// front classifies a byte in the cycle it is taken and queues it; the back
// sequencer emits one descriptor per cycle into a registered output
// whenever that register is free. When the sequencer was idle, the first
// descriptor passes through the queue, the job register and the output
// register; otherwise a queued byte follows the previous one with no gap.
// Output stalls hold the sequencer. The queue lets input transfers continue
// while the output is stalled, until it is full. The user must write
// configuration only while idle; the block itself does not enforce it.
module tape_pulse_train_encoder_unit #(
  parameter int unsigned QueueDepth = tpe_pkg::JOB_QUEUE_DEPTH
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [2:0]                  cfg_idx_i,
  input  logic [15:0]                 cfg_data_i,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [7:0]                  data_byte_i,
  input  logic                        first_of_block_i,
  input  logic                        last_of_block_i,
  input  logic [15:0]                 pause_ms_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [tpe_pkg::LEN_W-1:0]   pulse_length_o,
  output logic [tpe_pkg::CNT_W-1:0]   pulse_count_o,
  output logic                        end_of_run_o
);

  tpe_pkg::cfg_t cfg_q;
  tpe_pkg::job_t push_job, pop_job;
  logic          push, full, pop, job_valid;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mode               <= tpe_pkg::MODE_STD;
      cfg_q.pilot_length       <= tpe_pkg::STD_PILOT_LEN;
      cfg_q.pilot_count        <= tpe_pkg::STD_PILOT_DATA;
      cfg_q.first_sync_length  <= tpe_pkg::STD_SYNC1;
      cfg_q.second_sync_length <= tpe_pkg::STD_SYNC2;
      cfg_q.zero_length        <= tpe_pkg::STD_ZERO;
      cfg_q.one_length         <= tpe_pkg::STD_ONE;
      cfg_q.last_byte_bits     <= tpe_pkg::STD_BITS;
    end else if (cfg_we_i) begin
      unique case (tpe_pkg::reg_idx_e'(cfg_idx_i))
        tpe_pkg::REG_MODE:      cfg_q.mode               <= cfg_data_i[1:0];
        tpe_pkg::REG_PILOT_LEN: cfg_q.pilot_length       <= cfg_data_i;
        tpe_pkg::REG_PILOT_CNT: cfg_q.pilot_count        <= cfg_data_i;
        tpe_pkg::REG_SYNC1_LEN: cfg_q.first_sync_length  <= cfg_data_i;
        tpe_pkg::REG_SYNC2_LEN: cfg_q.second_sync_length <= cfg_data_i;
        tpe_pkg::REG_ZERO_LEN:  cfg_q.zero_length        <= cfg_data_i;
        tpe_pkg::REG_ONE_LEN:   cfg_q.one_length         <= cfg_data_i;
        tpe_pkg::REG_LAST_BITS: cfg_q.last_byte_bits     <= cfg_data_i[3:0];
        default: begin
        end
      endcase
    end
  end

  tpe_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_i            (cfg_q),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .data_byte_i      (data_byte_i),
    .first_of_block_i (first_of_block_i),
    .last_of_block_i  (last_of_block_i),
    .pause_ms_i       (pause_ms_i),
    .push_o           (push),
    .job_o            (push_job),
    .full_i           (full)
  );

  tpe_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_job),
    .full_o      (full),
    .pop_i       (pop),
    .valid_o     (job_valid),
    .pop_data_o  (pop_job)
  );

  tpe_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg_q),
    .job_valid_i    (job_valid),
    .job_i          (pop_job),
    .pop_o          (pop),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .pulse_length_o (pulse_length_o),
    .pulse_count_o  (pulse_count_o),
    .end_of_run_o   (end_of_run_o)
  );

endmodule
